[hdl/rsfm_pkg.sv]
package rsfm_pkg;

   // Request kinds carried in req_type.
   typedef enum logic [2:0] {
      REQ_ENCODER   = 3'd0,
      REQ_PROXIMITY = 3'd1,
      REQ_VELOCITY  = 3'd2,
      REQ_TICK      = 3'd3,
      REQ_CHECK     = 3'd4,
      REQ_REARM     = 3'd5
   } req_kind_type;

   // Fault codes carried in fault_code.
   typedef enum logic [1:0] {
      FAULT_STALL_MOVING = 2'd0,
      FAULT_PROX_LOST    = 2'd1,
      FAULT_BOTH_LOST    = 2'd2,
      FAULT_PROX_OFFRAIL = 2'd3
   } fault_kind_type;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STALL_LIMIT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODER_NOISE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVING_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_RAIL_CHECKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_RAIL_CHECKS  = 3'd4;

   localparam logic [15:0] STALL_LIMIT_RST      = 16'd1000;
   localparam logic [15:0] ENCODER_NOISE_RST    = 16'd0;
   localparam logic [14:0] MOVING_THRESHOLD_RST = 15'd50;

   // Output queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] encoder_count;
      logic [7:0]  proximity_sample;
      logic [15:0] velocity;
   } req_item_type;

   typedef struct packed {
      logic [1:0] fault_code;
      logic       last;
   } result_type;

   // Up to two results pushed into the output queue in one cycle.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

[hdl/rsfm_if.sv]
interface rsfm_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [31:0] encoder_count;
   logic [7:0]         proximity_sample;
   logic signed [15:0] velocity;

   modport source (output valid, req_type, encoder_count, proximity_sample, velocity,
                   input ready);
   modport sink (input valid, req_type, encoder_count, proximity_sample, velocity,
                 output ready);
endinterface

interface rsfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] fault_code;
   logic       last;

   modport source (output valid, fault_code, last, input ready);
   modport sink (input valid, fault_code, last, output ready);
endinterface

[hdl/rsfm_out_fifo.sv]
module rsfm_out_fifo import rsfm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       room2,
   output logic       not_empty,
   output result_type head
);

   result_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic [QUEUE_PTR_W-1:0]    wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_W'(1);
   assign room2       = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign not_empty   = count_ff != '0;
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/rail_sensor_fault_monitor.sv]
// Channel   Direction  Payload                                          Handshake
// req_ch    in         req_type, encoder_count, proximity_sample, vel.  valid/ready
// rsp_ch    out        fault_code, last                                 valid/ready
// csr       in         csr_index, csr_wdata                             csr_we
//
// One request word is taken per cycle while the input register can advance. An
// accepted word updates the monitor state and produces its faults from there.
// The input register advances only when the four-entry output queue has room for
// two words, so a stalled result side holds back requests after that queue fills.
// A check that raises two faults gives two words on the result side.
// Reset is synchronous and restores the register defaults and all monitor state.
module rail_sensor_fault_monitor import rsfm_pkg::*; #(
   parameter int WINDOW = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   rsfm_req_if.sink              req_ch,
   rsfm_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // The window sum never exceeds 255 per slot.
   localparam int SUM_W = $clog2(255 * WINDOW + 1);

   // Configuration registers.
   logic [15:0] stall_limit_ff;
   logic [15:0] encoder_noise_ff;
   logic [14:0] moving_threshold_ff;
   logic        on_rail_checks_ff;
   logic        off_rail_checks_ff;

   // Input register.
   logic         stg_valid_ff, stg_valid_in;
   req_item_type stg_item_ff;
   logic         stg_fire;
   logic         req_accept;

   // Monitor state.
   logic [7:0]       prox_window_ff [WINDOW];
   logic [7:0]       prox_window_in [WINDOW];
   logic [SUM_W-1:0] prox_sum_ff, prox_sum_in;
   logic             prox_on_ff, prox_on_in;
   logic [31:0]      current_count_ff, current_count_in;
   logic [31:0]      reference_count_ff, reference_count_in;
   logic [15:0]      stall_ticks_ff, stall_ticks_in;
   logic [15:0]      last_velocity_ff, last_velocity_in;

   // Fault evaluation.
   logic [32:0] enc_diff;
   logic [32:0] enc_dist;
   logic        enc_moved;
   logic [15:0] speed_mag;
   logic        moving;
   logic        stalled;
   logic        on_fault;
   logic [1:0]  on_code;
   logic        off_fault;

   push_type   push;
   logic       queue_room2;
   logic       queue_not_empty;
   result_type queue_head;

   assign req_accept   = req_ch.valid & req_ch.ready;
   assign stg_fire     = stg_valid_ff & queue_room2;
   assign req_ch.ready = ~stg_valid_ff | stg_fire;
   assign stg_valid_in = req_accept | (stg_valid_ff & ~stg_fire);

   // Configuration writes; an index past the last register is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         stall_limit_ff      <= STALL_LIMIT_RST;
         encoder_noise_ff    <= ENCODER_NOISE_RST;
         moving_threshold_ff <= MOVING_THRESHOLD_RST;
         on_rail_checks_ff   <= 1'b0;
         off_rail_checks_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STALL_LIMIT:      stall_limit_ff      <= csr_wdata;
            CSR_ENCODER_NOISE:    encoder_noise_ff    <= csr_wdata;
            CSR_MOVING_THRESHOLD: moving_threshold_ff <= csr_wdata[14:0];
            CSR_ON_RAIL_CHECKS:   on_rail_checks_ff   <= csr_wdata[0];
            CSR_OFF_RAIL_CHECKS:  off_rail_checks_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register: the payload is captured without reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_item_ff.kind             <= req_ch.req_type;
         stg_item_ff.encoder_count    <= req_ch.encoder_count;
         stg_item_ff.proximity_sample <= req_ch.proximity_sample;
         stg_item_ff.velocity         <= req_ch.velocity;
      end
   end

   // Encoder distance from the reference, exact on 33 bits.
   assign enc_diff  = {stg_item_ff.encoder_count[31], stg_item_ff.encoder_count}
                    - {reference_count_ff[31], reference_count_ff};
   assign enc_dist  = enc_diff[32] ? -enc_diff : enc_diff;
   assign enc_moved = enc_dist > {17'd0, encoder_noise_ff};

   // Speed magnitude; the most negative speed maps to 32768 as unsigned.
   assign speed_mag = last_velocity_ff[15] ? -last_velocity_ff : last_velocity_ff;
   assign moving    = speed_mag > {1'b0, moving_threshold_ff};

   assign stalled = stall_ticks_ff > stall_limit_ff;

   // On-rail checks: stall while moving, proximity lost, or both.
   always_comb begin
      on_fault = 1'b0;
      on_code  = FAULT_STALL_MOVING;
      if (on_rail_checks_ff) begin
         if (stalled && prox_on_ff && moving) begin
            on_fault = 1'b1;
            on_code  = FAULT_STALL_MOVING;
         end else if (!stalled && !prox_on_ff) begin
            on_fault = 1'b1;
            on_code  = FAULT_PROX_LOST;
         end else if (stalled && !prox_on_ff) begin
            on_fault = 1'b1;
            on_code  = FAULT_BOTH_LOST;
         end
      end
   end

   // Off-rail check sees the stall counter after an on-rail clear, which happens
   // exactly when on-rail checks found a stall with proximity while not moving.
   assign off_fault = off_rail_checks_ff & stalled & prox_on_ff
                    & ~(on_rail_checks_ff & ~moving);

   always_comb begin
      push.count             = 2'd0;
      push.first.fault_code  = on_fault ? on_code : FAULT_PROX_OFFRAIL;
      push.first.last        = ~(on_fault & off_fault);
      push.second.fault_code = FAULT_PROX_OFFRAIL;
      push.second.last       = 1'b1;
      if (stg_fire && stg_item_ff.kind == REQ_CHECK) begin
         push.count = 2'(on_fault) + 2'(off_fault);
      end
   end

   // State update for the word in the input register.
   always_comb begin
      prox_window_in     = prox_window_ff;
      prox_sum_in        = prox_sum_ff;
      prox_on_in         = prox_on_ff;
      current_count_in   = current_count_ff;
      reference_count_in = reference_count_ff;
      stall_ticks_in     = stall_ticks_ff;
      last_velocity_in   = last_velocity_ff;
      if (stg_fire) begin
         case (stg_item_ff.kind)
            REQ_ENCODER: begin
               if (enc_moved) begin
                  stall_ticks_in     = '0;
                  reference_count_in = stg_item_ff.encoder_count;
               end
               current_count_in = stg_item_ff.encoder_count;
            end
            REQ_PROXIMITY: begin
               for (int i = 0; i < WINDOW - 1; i++) begin
                  prox_window_in[i] = prox_window_ff[i + 1];
               end
               prox_window_in[WINDOW - 1] = stg_item_ff.proximity_sample;
               // Running sum: drop the oldest sample, add the new one.
               prox_sum_in = prox_sum_ff - SUM_W'(prox_window_ff[0])
                           + SUM_W'(stg_item_ff.proximity_sample);
               if (prox_sum_in >= SUM_W'(WINDOW - 1)) begin
                  prox_on_in = 1'b1;
               end else if (prox_sum_in <= SUM_W'(1)) begin
                  prox_on_in = 1'b0;
               end
            end
            REQ_VELOCITY: begin
               last_velocity_in = stg_item_ff.velocity;
            end
            REQ_TICK: begin
               if (stall_ticks_ff != 16'hFFFF) begin
                  stall_ticks_in = stall_ticks_ff + 16'd1;
               end
            end
            REQ_CHECK: begin
               if (on_rail_checks_ff && stalled && prox_on_ff && !moving) begin
                  stall_ticks_in = '0;
               end
            end
            REQ_REARM: begin
               reference_count_in = current_count_ff;
               stall_ticks_in     = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            prox_window_ff[i] <= '0;
         end
         prox_sum_ff        <= '0;
         prox_on_ff         <= 1'b0;
         current_count_ff   <= '0;
         reference_count_ff <= '0;
         stall_ticks_ff     <= '0;
         last_velocity_ff   <= '0;
      end else begin
         prox_window_ff     <= prox_window_in;
         prox_sum_ff        <= prox_sum_in;
         prox_on_ff         <= prox_on_in;
         current_count_ff   <= current_count_in;
         reference_count_ff <= reference_count_in;
         stall_ticks_ff     <= stall_ticks_in;
         last_velocity_ff   <= last_velocity_in;
      end
   end

   // Output queue decouples the result side from the input register.
   rsfm_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ch.valid & rsp_ch.ready),
      .room2     (queue_room2),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   assign rsp_ch.valid      = queue_not_empty;
   assign rsp_ch.fault_code = queue_head.fault_code;
   assign rsp_ch.last       = queue_head.last;

endmodule

[hdl/rsfm_checker.sv]
module rsfm_checker import rsfm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_fault_code,
   input logic       rsp_last
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_code) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // The second word of a check is queued with the first, so it is shown at once.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("second fault word not available after a non-final word");

   // A two-fault check is always a moving stall followed by the off-rail fault.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last
      |-> rsp_fault_code == FAULT_STALL_MOVING
      ##1 rsp_fault_code == FAULT_PROX_OFFRAIL && rsp_last)
      else $error("bad fault pair");

   // Nothing is left in the result queue after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind rail_sensor_fault_monitor rsfm_checker u_rsfm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_fault_code (rsp_ch.fault_code),
   .rsp_last       (rsp_ch.last)
);

[test/tb_rail_sensor_fault_monitor.sv]
module tb_rail_sensor_fault_monitor;
   import rsfm_pkg::*;

   // The proximity window depth handed to the block and to the predictor below.
   localparam int WINDOW = 3;

   // The watchdog is far above the slowest legal run, which is dominated by the
   // long gaps on both sides of random words and by the long receiver hold-off.
   localparam int CYCLE_LIMIT = 200_000;

   // A word passes through the input register before its faults reach the output
   // queue, so the block is idle once this settle time follows the last fault word.
   localparam int SETTLE_CYCLES = 8;

   // Request codes that the block must ignore.
   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_WORDS     = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_CHECKS = 40;
   localparam int MAX_PRINTED     = 100;

   typedef struct packed {
      fault_kind_type code;
      logic           last;
   } fault_word_type;

   // The scoreboard keeps its own copy of the monitor state and registers. Every
   // accepted request word is run through it, and the fault words it would raise
   // are queued in order; every fault word from the block is matched against the
   // oldest entry.
   class fault_scoreboard_type;
      logic [15:0] stall_limit;
      logic [15:0] encoder_noise;
      logic [14:0] moving_threshold;
      logic        on_rail_checks;
      logic        off_rail_checks;

      logic [7:0]  prox_window [WINDOW];
      logic        prox_on;
      logic [31:0] current_count;
      logic [31:0] reference_count;
      logic [15:0] stall_ticks;
      logic [15:0] last_velocity;

      fault_word_type expected_faults [$];
      int             errors;

      function new();
         stall_limit      = STALL_LIMIT_RST;
         encoder_noise    = ENCODER_NOISE_RST;
         moving_threshold = MOVING_THRESHOLD_RST;
         on_rail_checks   = 1'b0;
         off_rail_checks  = 1'b0;
         foreach (prox_window[i]) prox_window[i] = '0;
         prox_on          = 1'b0;
         current_count    = '0;
         reference_count  = '0;
         stall_ticks      = '0;
         last_velocity    = '0;
         errors           = 0;
      endfunction

      // Narrow registers keep only their low bits, like the hardware.
      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_STALL_LIMIT:      stall_limit      = data;
            CSR_ENCODER_NOISE:    encoder_noise    = data;
            CSR_MOVING_THRESHOLD: moving_threshold = data[14:0];
            CSR_ON_RAIL_CHECKS:   on_rail_checks   = data[0];
            CSR_OFF_RAIL_CHECKS:  off_rail_checks  = data[0];
            default: ;
         endcase
      endfunction

      function void add_fault(fault_kind_type code);
         fault_word_type w;
         w.code = code;
         w.last = 1'b0;
         expected_faults.insert(expected_faults.size(), w);
      endfunction

      function void predict_faults(req_item_type word);
         longint delta;
         int     sum;
         int     speed;
         int     first;
         logic   stalled;
         case (word.kind)
            REQ_ENCODER: begin
               // The distance is taken on the full signed range, with no wrap.
               delta = longint'($signed(word.encoder_count))
                       - longint'($signed(reference_count));
               if (delta < 0) delta = -delta;
               if (delta > longint'(encoder_noise)) begin
                  stall_ticks     = '0;
                  reference_count = word.encoder_count;
               end
               current_count = word.encoder_count;
            end
            REQ_PROXIMITY: begin
               for (int i = 0; i < WINDOW - 1; i++) prox_window[i] = prox_window[i + 1];
               prox_window[WINDOW - 1] = word.proximity_sample;
               sum = 0;
               foreach (prox_window[i]) sum += prox_window[i];
               // The turn-on test comes first, so it wins where both hold.
               if (sum >= WINDOW - 1) prox_on = 1'b1;
               else if (sum <= 1) prox_on = 1'b0;
            end
            REQ_VELOCITY: last_velocity = word.velocity;
            REQ_TICK: begin
               if (stall_ticks != 16'hFFFF) stall_ticks++;
            end
            REQ_CHECK: begin
               first = expected_faults.size();
               if (on_rail_checks) begin
                  stalled = stall_ticks > stall_limit;
                  if (stalled && prox_on) begin
                     speed = int'($signed(last_velocity));
                     if (speed < 0) speed = -speed;
                     if (speed > int'(moving_threshold)) add_fault(FAULT_STALL_MOVING);
                     else stall_ticks = '0;
                  end else if (!stalled && !prox_on) begin
                     add_fault(FAULT_PROX_LOST);
                  end else if (stalled && !prox_on) begin
                     add_fault(FAULT_BOTH_LOST);
                  end
               end
               // The off-rail test sees a counter cleared by the on-rail test.
               if (off_rail_checks && (stall_ticks > stall_limit) && prox_on)
                  add_fault(FAULT_PROX_OFFRAIL);
               if (expected_faults.size() > first)
                  expected_faults[expected_faults.size() - 1].last = 1'b1;
            end
            REQ_REARM: begin
               reference_count = current_count;
               stall_ticks     = '0;
            end
            default: ;
         endcase
      endfunction

      // Every mismatch is counted; printing stops after a while so that a badly
      // broken block does not flood the log.
      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_fault(logic [1:0] code, logic last);
         fault_word_type want;
         if (expected_faults.size() == 0) begin
            report($sformatf("fault word code %0d last %0b with none expected", code, last));
            return;
         end
         want = expected_faults.pop_front();
         if (code !== want.code)
            report($sformatf("fault_code %0d, expected %0d", code, want.code));
         if (last !== want.last)
            report($sformatf("last %0b, expected %0b (code %0d)", last, want.last, want.code));
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rsfm_req_if req_ch ();
   rsfm_rsp_if rsp_ch ();

   fault_scoreboard_type sb = new();

   // Stimulus side knobs; hold_off_request is shared by the sender and receiver.
   bit           tx_idling        = 1'b1;
   bit           rx_idling        = 1'b1;
   int           hold_off_request = 0;
   int           cycle_count      = 0;
   logic [31:0]  enc_base         = '0;
   int           cur_noise        = 0;
   int           cur_thr          = 50;
   req_item_type seen_word;

   rail_sensor_fault_monitor #(.WINDOW(WINDOW)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is held from the start and released on a falling edge.
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   // The watchdog ends a run that hangs, for example when the block stops
   // accepting words or never delivers an expected fault word.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge, where the inputs driven on the
   // falling edge are stable. A fault word is matched before the request of the
   // same edge is predicted, since it can only come from an older request.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_fault(rsp_ch.fault_code, rsp_ch.last);
         if (req_ch.valid && req_ch.ready) begin
            seen_word = {req_ch.req_type, req_ch.encoder_count, req_ch.proximity_sample,
                         req_ch.velocity};
            sb.predict_faults(seen_word);
         end
      end
   end

   // Most gaps are zero or short, a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else if (r < 99) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // The receiver decides ready once per falling edge. A hold-off asked for by the
   // sender is counted down here, in cycles, independently of the sender.
   initial begin
      int idle_left;
      idle_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            idle_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (idle_left > 0) begin
            rsp_ch.ready <= 1'b0;
            idle_left--;
         end else if (rx_idling && $urandom_range(0, 99) < 20) begin
            rsp_ch.ready <= 1'b0;
            idle_left = pick_gap();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offers one request word and returns at the edge that takes it. Valid stays
   // high afterwards, so back-to-back words need no extra assignment to it.
   task automatic send_word(input logic [2:0] kind, input logic [31:0] enc,
                            input logic [7:0] prox, input logic [15:0] vel);
      int gap;
      gap = tx_idling ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.req_type         <= kind;
      req_ch.encoder_count    <= enc;
      req_ch.proximity_sample <= prox;
      req_ch.velocity         <= vel;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // Stops offering words and waits until every expected fault word has come,
   // then lets the input register empty so that registers may be rewritten.
   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.expected_faults.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] index,
                          input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      sb.write_reg(index, data);
   endtask

   // Writes all five registers back to back. The unused upper bits of the narrow
   // registers carry random values, which the block must drop.
   task automatic set_config(input logic [15:0] limit, input logic [15:0] noise,
                             input logic [14:0] thr, input logic on_rail,
                             input logic off_rail);
      put_reg(CSR_STALL_LIMIT, limit);
      put_reg(CSR_ENCODER_NOISE, noise);
      put_reg(CSR_MOVING_THRESHOLD, {1'($urandom), thr});
      put_reg(CSR_ON_RAIL_CHECKS, {15'($urandom), on_rail});
      put_reg(CSR_OFF_RAIL_CHECKS, {15'($urandom), off_rail});
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_noise = int'(noise);
      cur_thr   = int'(thr);
   endtask

   // Random words are shaped so that the interesting states are reached: encoder
   // counts land mostly near the noise margin around the last count, proximity
   // bytes are mostly 0, 1 or 2 so the window sum crosses both thresholds, and
   // speeds sit mostly right at the moving threshold. Ticks are frequent enough to
   // pass the small stall limits used by most phases.
   task automatic send_random_word();
      logic [2:0]  kind;
      logic [31:0] enc;
      logic [7:0]  prox;
      logic [15:0] vel;
      int          pick;
      int          span;
      int          mag;
      enc  = $urandom;
      prox = 8'($urandom);
      vel  = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         kind = REQ_ENCODER;
         if ($urandom_range(0, 3) != 0) begin
            span = cur_noise + 2;
            enc  = enc_base + 32'($urandom_range(0, 2 * span)) - 32'(span);
         end
         enc_base = enc;
      end else if (pick < 34) begin
         kind = REQ_PROXIMITY;
         mag  = $urandom_range(0, 9);
         if (mag < 4) prox = 8'd0;
         else if (mag < 8) prox = 8'd1;
         else if (mag < 9) prox = 8'd2;
      end else if (pick < 44) begin
         kind = REQ_VELOCITY;
         if ($urandom_range(0, 2) != 0) begin
            mag = cur_thr + int'($urandom_range(0, 2)) - 1;
            vel = ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
         end
      end else if (pick < 75) begin
         kind = REQ_TICK;
      end else if (pick < 93) begin
         kind = REQ_CHECK;
      end else if (pick < 97) begin
         kind = REQ_REARM;
      end else begin
         kind = ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
      end
      send_word(kind, enc, prox, vel);
   endtask

   initial begin
      req_ch.valid            <= 1'b0;
      req_ch.req_type         <= REQ_TICK;
      req_ch.encoder_count    <= '0;
      req_ch.proximity_sample <= '0;
      req_ch.velocity         <= '0;
      csr_we                  <= 1'b0;
      csr_index               <= CSR_STALL_LIMIT;
      csr_wdata               <= '0;
      wait (reset === 1'b0);

      // With the reset register values both check groups are off, so a check
      // word raises nothing.
      send_word(REQ_CHECK, '0, '0, '0);
      wait_quiet();

      // Directed part: stall limit 1, noise margin 5, threshold 50, both on.
      set_config(16'd1, 16'd5, 15'd50, 1'b1, 1'b1);
      // Not stalled and proximity off: proximity lost.
      send_word(REQ_CHECK, '0, '0, '0);
      // A full byte, then zeros that empty the window, then two ones that bring
      // the sum to the turn-on level.
      send_word(REQ_PROXIMITY, '0, 8'hFF, '0);
      repeat (3) send_word(REQ_PROXIMITY, '0, 8'h00, '0);
      repeat (2) send_word(REQ_PROXIMITY, '0, 8'h01, '0);
      // Two ticks pass the limit. The most negative speed is moving, so the check
      // raises a stall while moving and then the off-rail fault.
      repeat (2) send_word(REQ_TICK, '0, '0, '0);
      send_word(REQ_VELOCITY, '0, '0, 16'h8000);
      send_word(REQ_CHECK, '0, '0, '0);
      // Standing still: the stall is cleared, and the off-rail test then sees it
      // cleared, so nothing is raised.
      send_word(REQ_VELOCITY, '0, '0, 16'h0000);
      send_word(REQ_CHECK, '0, '0, '0);
      // Empty the window, stall again: both lost.
      repeat (3) send_word(REQ_PROXIMITY, '0, 8'h00, '0);
      repeat (2) send_word(REQ_TICK, '0, '0, '0);
      send_word(REQ_CHECK, '0, '0, '0);
      // A change equal to the margin is noise; one more count is motion.
      send_word(REQ_ENCODER, 32'd5, '0, '0);
      send_word(REQ_ENCODER, 32'd6, '0, '0);
      send_word(REQ_CHECK, '0, '0, '0);
      // Jumps across the whole signed range must not wrap.
      send_word(REQ_ENCODER, 32'h8000_0000, '0, '0);
      send_word(REQ_ENCODER, 32'h7FFF_FFFF, '0, '0);
      send_word(REQ_TICK, '0, '0, '0);
      send_word(REQ_REARM, '0, '0, '0);
      send_word(REQ_CHECK, '0, '0, '0);
      send_word(REQ_SPARE_LO, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      send_word(REQ_SPARE_HI, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      wait_quiet();

      // Back pressure: the receiver holds off for a long stretch while check
      // words keep coming, each raising a fault, so the output queue fills and
      // the block must stop taking requests.
      set_config(16'd1000, 16'd0, 15'd50, 1'b1, 1'b0);
      tx_idling        = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (HOLD_OFF_CHECKS) send_word(REQ_CHECK, '0, '0, '0);
      wait_quiet();

      // Random part: each phase runs under its own register setting. The first four
      // phases take fixed settings, among them the extremes; the rest take random settings with small stall limits.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_quiet();
         case (phase)
            0: set_config(16'd3, 16'd8, 15'd50, 1'b1, 1'b1);
            1: set_config(16'd0, 16'd0, 15'd0, 1'b1, 1'b0);
            2: set_config(16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, 1'b1);
            3: set_config(16'd2, 16'd100, 15'd1000, 1'b0, 1'b1);
            default:
               set_config(16'($urandom_range(0, 6)),
                          ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : 16'($urandom_range(0, 300)),
                          15'($urandom_range(0, 600)), $urandom_range(0, 3) != 0,
                          1'($urandom_range(0, 1)));
         endcase
         // Phases alternate between idling on both sides, none at all, and
         // idling on the receiver only.
         tx_idling = (phase % 3) == 0;
         rx_idling = (phase % 3) != 1;
         repeat (PHASE_WORDS) send_random_word();
      end

      tx_idling = 1'b1;
      rx_idling = 1'b1;
      wait_quiet();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
